@@ rtl/idbrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbrc_pkg
// Shared types, sizes and helpers of the rectangle collision block.
// ----------------------------------------------------------------------------
package idbrc_pkg;

  // Screen and batch limits
  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 256;
  localparam int MAX_RECTS     = 64;

  // Field widths
  localparam int POS_W = 8;
  localparam int LEN_W = 9;
  localparam int END_W = 9;
  localparam int ID_W  = 16;
  localparam int IDX_W = 6;

  // Rectangle table
  localparam int TBL_DEPTH = 64;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int CNT_W     = TBL_AW + 1;

  // Frame buffer
  localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int FRAME_AW   = $clog2(FRAME_SIZE);

  // Width for clipping arithmetic: holds start + length and the screen limits
  localparam int SCR_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int CALC_W  = $clog2(SCR_MAX + 512) + 1;

  // Batch command queue
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [ID_W-1:0] BG_ID = '0;

  typedef struct packed {
    logic [POS_W-1:0] rect_x;
    logic [POS_W-1:0] rect_y;
    logic [LEN_W-1:0] rect_width;
    logic [LEN_W-1:0] rect_height;
    logic [ID_W-1:0]  entity_id;
    logic             last_rect;
  } rect_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] rect_index;
    logic             collided;
    logic             last_flag;
  } result_t;

  // Clipped, half-open bounds of one stored rectangle
  typedef struct packed {
    logic [POS_W-1:0] x0;
    logic [POS_W-1:0] y0;
    logic [END_W-1:0] x1;
    logic [END_W-1:0] y1;
    logic [ID_W-1:0]  id;
  } rect_entry_t;

  localparam int ENTRY_W = $bits(rect_entry_t);

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] addr;
    rect_entry_t       data;
  } tbl_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } batch_cmd_t;

  // End of a span, clipped to the screen limit and never before its start
  function automatic logic [END_W-1:0] clip_end(input logic [POS_W-1:0]  start_pos,
                                                input logic [LEN_W-1:0]  len,
                                                input logic [CALC_W-1:0] limit);
    logic [CALC_W-1:0] s;
    logic [CALC_W-1:0] e;
    s = CALC_W'(start_pos);
    e = s + CALC_W'(len);
    if (e > limit) begin
      e = limit;
    end
    if (e < s) begin
      e = s;
    end
    return END_W'(e);
  endfunction

  // Linear frame address of an on-screen pixel
  function automatic logic [FRAME_AW-1:0] frame_addr(input logic [END_W-1:0] y,
                                                     input logic [END_W-1:0] x);
    return FRAME_AW'(FRAME_AW'(y) * FRAME_AW'(SCREEN_WIDTH) + FRAME_AW'(x));
  endfunction

endpackage

@@ rtl/idbrc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idbrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/idbrc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbrc_front
// Load side: clip each request, store it in the table, post a batch command.
// ----------------------------------------------------------------------------
module idbrc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  idbrc_pkg::rect_in_t   in_rect,
  output idbrc_pkg::tbl_wr_t    tbl_wr,
  output logic                  cmd_push,
  output idbrc_pkg::batch_cmd_t cmd
);
  import idbrc_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             room;
  logic [CNT_W-1:0] cnt_inc;

  assign room    = (cnt_r < CNT_W'(MAX_RECTS));
  assign cnt_inc = room ? (cnt_r + CNT_W'(1)) : cnt_r;

  always_comb begin
    tbl_wr.we      = accept && room;
    tbl_wr.addr    = cnt_r[TBL_AW-1:0];
    tbl_wr.data.x0 = in_rect.rect_x;
    tbl_wr.data.y0 = in_rect.rect_y;
    tbl_wr.data.x1 = clip_end(in_rect.rect_x, in_rect.rect_width, CALC_W'(SCREEN_WIDTH));
    tbl_wr.data.y1 = clip_end(in_rect.rect_y, in_rect.rect_height, CALC_W'(SCREEN_HEIGHT));
    tbl_wr.data.id = in_rect.entity_id;
  end

  assign cmd_push  = accept && in_rect.last_rect;
  assign cmd.count = cnt_inc;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      // drop the count back to zero once the batch is closed
      cnt_nxt = in_rect.last_rect ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/idbrc_cmd_q.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbrc_cmd_q
// Short queue of batch commands between the load side and the engine.
// ----------------------------------------------------------------------------
module idbrc_cmd_q (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  idbrc_pkg::batch_cmd_t push_cmd,
  input  logic                  pop,
  output logic                  cmd_valid,
  output idbrc_pkg::batch_cmd_t cmd
);
  import idbrc_pkg::*;

  batch_cmd_t         mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_AW:0]   fill_r;
  logic [CMDQ_AW-1:0] wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_nxt;
  logic [CMDQ_AW:0]   fill_nxt;
  logic               do_push;
  logic               do_pop;

  assign cmd_valid = (fill_r != '0);
  assign cmd       = mem_r[rd_ptr_r];
  assign do_push   = push && (fill_r != (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign do_pop    = pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + CMDQ_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + CMDQ_AW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (CMDQ_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - (CMDQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

@@ rtl/idbrc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbrc_back
// Batch engine: clear the frame, paint every rectangle, scan and report.
// ----------------------------------------------------------------------------
module idbrc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  idbrc_pkg::batch_cmd_t             cmd,
  output logic                              cmd_pop,
  output logic                              engine_busy,
  output logic [idbrc_pkg::TBL_AW-1:0]      tbl_raddr,
  input  idbrc_pkg::rect_entry_t            tbl_rdata,
  output logic                              frm_we,
  output logic [idbrc_pkg::FRAME_AW-1:0]    frm_waddr,
  output logic [idbrc_pkg::ID_W-1:0]        frm_wdata,
  output logic [idbrc_pkg::FRAME_AW-1:0]    frm_raddr,
  input  logic [idbrc_pkg::ID_W-1:0]        frm_rdata,
  output logic                              out_strobe,
  output idbrc_pkg::result_t                out_result
);
  import idbrc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_PFETCH = 3'd2;
  localparam logic [2:0] S_PLOAD  = 3'd3;
  localparam logic [2:0] S_PAINT  = 3'd4;
  localparam logic [2:0] S_SFETCH = 3'd5;
  localparam logic [2:0] S_SLOAD  = 3'd6;
  localparam logic [2:0] S_SCAN   = 3'd7;

  logic [2:0]          state_r,      state_nxt;
  logic [CNT_W-1:0]    k_r,          k_nxt;
  logic [CNT_W-1:0]    n_r,          n_nxt;
  logic [FRAME_AW-1:0] clr_r,        clr_nxt;
  rect_entry_t         cur_r,        cur_nxt;
  logic [END_W-1:0]    x_r,          x_nxt;
  logic [END_W-1:0]    y_r,          y_nxt;
  logic                pend_r,       pend_nxt;
  logic                pend_last_r,  pend_last_nxt;
  logic                issued_r,     issued_nxt;
  logic                strobe_r,     strobe_nxt;
  result_t             res_r,        res_nxt;

  logic                last_rect;
  logic                load_empty;
  logic                x_end;
  logic                y_end;

  assign last_rect  = ((k_r + CNT_W'(1)) == n_r);
  assign load_empty = !((END_W'(tbl_rdata.x0) < tbl_rdata.x1) &&
                        (END_W'(tbl_rdata.y0) < tbl_rdata.y1));
  assign x_end      = ((x_r + END_W'(1)) == cur_r.x1);
  assign y_end      = ((y_r + END_W'(1)) == cur_r.y1);

  assign engine_busy = (state_r != S_IDLE);
  assign out_strobe  = strobe_r;
  assign out_result  = res_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    issued_nxt    = issued_r;
    strobe_nxt    = 1'b0;
    res_nxt       = res_r;
    cmd_pop       = 1'b0;
    tbl_raddr     = k_r[TBL_AW-1:0];
    frm_we        = 1'b0;
    frm_waddr     = clr_r;
    frm_wdata     = BG_ID;
    frm_raddr     = frame_addr(y_r, x_r);

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          n_nxt     = cmd.count;
          clr_nxt   = '0;
          state_nxt = S_CLEAR;
        end
      end

      S_CLEAR: begin
        frm_we = 1'b1;
        if (clr_r == FRAME_AW'(FRAME_SIZE - 1)) begin
          k_nxt     = '0;
          state_nxt = S_PFETCH;
        end else begin
          clr_nxt = clr_r + FRAME_AW'(1);
        end
      end

      S_PFETCH: begin
        state_nxt = S_PLOAD;
      end

      S_PLOAD: begin
        cur_nxt = tbl_rdata;
        x_nxt   = END_W'(tbl_rdata.x0);
        y_nxt   = END_W'(tbl_rdata.y0);
        if (!load_empty) begin
          state_nxt = S_PAINT;
        end else if (last_rect) begin
          k_nxt     = '0;
          state_nxt = S_SFETCH;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_PFETCH;
        end
      end

      S_PAINT: begin
        frm_we    = 1'b1;
        frm_waddr = frame_addr(y_r, x_r);
        frm_wdata = cur_r.id;
        if (x_end) begin
          x_nxt = END_W'(cur_r.x0);
          if (y_end) begin
            if (last_rect) begin
              k_nxt     = '0;
              state_nxt = S_SFETCH;
            end else begin
              k_nxt     = k_r + CNT_W'(1);
              state_nxt = S_PFETCH;
            end
          end else begin
            y_nxt = y_r + END_W'(1);
          end
        end else begin
          x_nxt = x_r + END_W'(1);
        end
      end

      S_SFETCH: begin
        state_nxt = S_SLOAD;
      end

      S_SLOAD: begin
        cur_nxt    = tbl_rdata;
        x_nxt      = END_W'(tbl_rdata.x0);
        y_nxt      = END_W'(tbl_rdata.y0);
        pend_nxt   = 1'b0;
        issued_nxt = 1'b0;
        if (!load_empty) begin
          state_nxt = S_SCAN;
        end else begin
          strobe_nxt         = 1'b1;
          res_nxt.rect_index = k_r[IDX_W-1:0];
          res_nxt.collided   = 1'b0;
          res_nxt.last_flag  = last_rect;
          if (last_rect) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = S_SFETCH;
          end
        end
      end

      S_SCAN: begin
        // issue one pixel read a cycle, check each one in the cycle after
        pend_nxt = !issued_r;
        if (!issued_r) begin
          pend_last_nxt = x_end && y_end;
          issued_nxt    = x_end && y_end;
          if (x_end) begin
            x_nxt = END_W'(cur_r.x0);
            if (!y_end) begin
              y_nxt = y_r + END_W'(1);
            end
          end else begin
            x_nxt = x_r + END_W'(1);
          end
        end
        if (pend_r && ((frm_rdata != cur_r.id) || pend_last_r)) begin
          strobe_nxt         = 1'b1;
          res_nxt.rect_index = k_r[IDX_W-1:0];
          res_nxt.collided   = (frm_rdata != cur_r.id);
          res_nxt.last_flag  = last_rect;
          if (last_rect) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = S_SFETCH;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
      pend_r   <= 1'b0;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      pend_r   <= pend_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    n_r         <= n_nxt;
    clr_r       <= clr_nxt;
    cur_r       <= cur_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    pend_last_r <= pend_last_nxt;
    res_r       <= res_nxt;
  end

endmodule

@@ rtl/id_buffer_rect_collision.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_buffer_rect_collision
// Rectangle overlap detection through an id frame buffer.
// ----------------------------------------------------------------------------
// Requests load one per cycle while busy is low; the request marked last
// closes the batch and raises busy. The engine then clears the 65536-entry
// frame RAM (one pixel per cycle), paints each rectangle's clipped area in
// load order and scans each rectangle's area up to the first foreign id or
// its last pixel, reporting one result per rectangle in load order. All
// three phases share the single frame RAM port pair. Each result appears
// on out_result for exactly one cycle with out_strobe high; the receiver
// has no way to hold it off, so it must take every strobe.
// Up to 64 rectangles fit in a batch; extra ones are dropped, and the batch
// still closes on the last-marked request.
module id_buffer_rect_collision (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  idbrc_pkg::rect_in_t in_rect,
  output logic                out_strobe,
  output idbrc_pkg::result_t  out_result
);
  import idbrc_pkg::*;

  logic                accept;
  tbl_wr_t             tbl_wr;
  logic                cmd_push;
  batch_cmd_t          push_cmd;
  logic                cmd_valid;
  batch_cmd_t          cmd;
  logic                cmd_pop;
  logic                engine_busy;
  logic [TBL_AW-1:0]   tbl_raddr;
  logic [ENTRY_W-1:0]  tbl_rdata;
  logic                frm_we;
  logic [FRAME_AW-1:0] frm_waddr;
  logic [ID_W-1:0]     frm_wdata;
  logic [FRAME_AW-1:0] frm_raddr;
  logic [ID_W-1:0]     frm_rdata;

  // Hold off requests while a batch waits in the queue or is in the engine
  assign busy   = cmd_valid || engine_busy;
  assign accept = start && !busy;

  // Clip and store each request; post the batch on the last one
  idbrc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_rect  (in_rect),
    .tbl_wr   (tbl_wr),
    .cmd_push (cmd_push),
    .cmd      (push_cmd)
  );

  // Rectangle table: written by the load side, read by the engine
  idbrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_wr.we),
    .waddr (tbl_wr.addr),
    .wdata (tbl_wr.data),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Batch commands between load side and engine
  idbrc_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_cmd  (push_cmd),
    .pop       (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // Clear, paint and scan the frame, emit results
  idbrc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .engine_busy (engine_busy),
    .tbl_raddr   (tbl_raddr),
    .tbl_rdata   (rect_entry_t'(tbl_rdata)),
    .frm_we      (frm_we),
    .frm_waddr   (frm_waddr),
    .frm_wdata   (frm_wdata),
    .frm_raddr   (frm_raddr),
    .frm_rdata   (frm_rdata),
    .out_strobe  (out_strobe),
    .out_result  (out_result)
  );

  // Id frame buffer, one id per pixel
  idbrc_ram #(
    .WIDTH (ID_W),
    .DEPTH (FRAME_SIZE)
  ) u_frm_ram (
    .clk   (clk),
    .we    (frm_we),
    .waddr (frm_waddr),
    .wdata (frm_wdata),
    .raddr (frm_raddr),
    .rdata (frm_rdata)
  );

endmodule
